FILE: hdl/bqlp_pkg.sv
// ----------------------------------------------------------------------------
// bqlp_pkg
// Types and constants shared by the biquad low-pass core.
// ----------------------------------------------------------------------------
`default_nettype none
package bqlp_pkg;

  localparam int unsigned BILIN_K    = 15287;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned FB_SHIFT   = 30;
  localparam int unsigned NORM_SHIFT = 25;
  localparam logic signed [31:0] CUT_MIN   = 32'sd15;
  localparam logic signed [31:0] CUT_MAX   = 32'sd15000;
  localparam logic signed [31:0] RES_MIN   = 32'sd140;
  localparam logic signed [31:0] LAST_CUT_RST = 32'sd16777216;

  // queue entry between front and back
  typedef struct packed {
    logic               recalc;
    logic signed [15:0] smp;
    logic signed [15:0] cut;
    logic signed [15:0] res;
    logic signed [15:0] gain;
  } bqlp_item_t;

  typedef enum logic [3:0] {
    B_IDLE, B_QDIV, B_A1M, B_A1S, B_SUM, B_NDIV, B_C0, B_C1, B_C2,
    B_F0, B_F1, B_F2, B_F3, B_G, B_OUT
  } bqlp_bstate_t;

endpackage
`default_nettype wire

FILE: hdl/bqlp_div.sv
// ----------------------------------------------------------------------------
// bqlp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bqlp_div #(
  parameter int unsigned W = 58
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic [W-1:0]      quotient
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0] rem_r, rem_nxt, q_r, q_nxt, d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [W:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[W-1]} - {1'b0, d_r};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], q_r[W-1]};
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) d_r <= divisor;
  end

  assign busy     = busy_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

FILE: hdl/bqlp_front.sv
// ----------------------------------------------------------------------------
// bqlp_front
// Accepts words, flags coefficient changes and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module bqlp_front
  import bqlp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_sample_in,
  input  wire logic signed [15:0] in_cutoff,
  input  wire logic signed [15:0] in_resonance,
  input  wire logic signed [15:0] in_gain,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output bqlp_item_t              q_item
);
  bqlp_item_t mem_r [2];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic signed [31:0] last_cut_r, last_cut_nxt;
  logic signed [15:0] last_res_r, last_res_nxt;
  logic push;
  bqlp_item_t it;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    it.smp    = in_sample_in;
    it.cut    = in_cutoff;
    it.res    = in_resonance;
    it.gain   = in_gain;
    it.recalc = (32'(in_cutoff) != last_cut_r) || (in_resonance != last_res_r);
    last_cut_nxt = push ? 32'(in_cutoff) : last_cut_r;
    last_res_nxt = push ? in_resonance : last_res_r;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
      last_cut_r <= LAST_CUT_RST;
      last_res_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
      last_cut_r <= last_cut_nxt;
      last_res_r <= last_res_nxt;
    end
    if (push) mem_r[wp_r] <= it;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];
endmodule
`default_nettype wire

FILE: hdl/bqlp_back.sv
// ----------------------------------------------------------------------------
// bqlp_back
// Coefficient sequencer and filter recursion, one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module bqlp_back
  import bqlp_pkg::*;
#(
  parameter int unsigned GAIN_SHIFT = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire bqlp_item_t         q_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_sample_out
);
  localparam int unsigned DW = 32 + NORM_SHIFT + 1;

  bqlp_bstate_t st_r, st_nxt;
  bqlp_item_t   it_r;
  logic signed [31:0] a0c, a1_r, a2_r, sum_r, rec_r, qrec_r;
  logic signed [31:0] fc_r, fb0_r, fb1_r;
  logic signed [31:0] acc_r, ret_r;
  logic signed [31:0] acc_sh;
  logic signed [63:0] y_r;
  logic signed [15:0] ih_r [3];
  logic signed [31:0] oh_r [3];
  logic [1:0] rp_r, rp_n;
  logic [1:0] p0, p1;
  logic signed [31:0] fq, qq;
  logic div_start, div_busy;
  logic [DW-1:0] div_a, div_b, div_q;
  logic signed [32:0] m_a, m_b;
  logic signed [63:0] m_p;
  logic signed [31:0] m_hi;
  logic signed [15:0] sat;
  logic signed [63:0] ysh;

  bqlp_div #(.W(DW)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q)
  );

  assign a0c = 32'(BILIN_K * BILIN_K);
  // shared 33x33 signed multiplier
  assign m_p  = 64'(m_a * m_b);
  assign m_hi = m_p[63:32];
  assign acc_sh = acc_r << FRAC_SHIFT;

  always_comb begin
    fq = 32'(it_r.cut);
    if (fq < CUT_MIN) fq = CUT_MIN;
    if (fq > CUT_MAX) fq = CUT_MAX;
    qq = 32'(it_r.res);
    if (qq < RES_MIN) qq = RES_MIN;
    rp_n = (rp_r == 2'd2 || rp_r == 2'd3) ? 2'd0 : rp_r + 2'd1;
    p0 = (rp_n == 2'd0) ? 2'd2 : rp_n - 2'd1;
    p1 = (p0 == 2'd0) ? 2'd2 : p0 - 2'd1;
    ysh = y_r >>> GAIN_SHIFT;
    if (ysh > 64'sd32767) sat = 16'sh7fff;
    else if (ysh < -64'sd32768) sat = 16'sh8000;
    else sat = ysh[15:0];
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    div_start = 1'b0;
    div_a = '0;
    div_b = '0;
    m_a = '0;
    m_b = '0;
    case (st_r)
      B_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        st_nxt = q_item.recalc ? B_QDIV : B_F0;
      end
      B_QDIV: begin
        div_start = 1'b1;
        div_a = DW'(64'h8000_0000);
        div_b = DW'(qq + 32'sd1);
        st_nxt = B_A1M;
      end
      B_A1M: begin
        m_a = 33'(BILIN_K * 8);
        m_b = 33'(fq);
        if (!div_busy) st_nxt = B_A1S;
      end
      B_A1S: begin
        m_a = 33'(a1_r);
        m_b = {1'b0, qrec_r};
        st_nxt = B_SUM;
      end
      B_SUM: st_nxt = B_NDIV;
      B_NDIV: begin
        div_start = 1'b1;
        div_a = DW'(1) << (32 + NORM_SHIFT);
        div_b = DW'(sum_r);
        st_nxt = B_C0;
      end
      B_C0: begin
        if (!div_busy) begin
          // reciprocal straight from the divider, rec_r loads this cycle
          m_a = 33'(a2_r);
          m_b = (sum_r > 0) ? {1'b0, div_q[31:0]} : '0;
          st_nxt = B_C1;
        end
      end
      B_C1: begin
        m_a = 33'(32'(2 * (64'(a2_r) - 64'(a0c))));
        m_b = 33'(rec_r);
        st_nxt = B_C2;
      end
      B_C2: begin
        m_a = 33'(32'(a0c - a1_r + a2_r));
        m_b = 33'(rec_r);
        st_nxt = B_F0;
      end
      B_F0: begin
        m_a = 33'(oh_r[p0]);
        m_b = 33'(fb0_r);
        st_nxt = B_F1;
      end
      B_F1: begin
        m_a = 33'(oh_r[p1]);
        m_b = 33'(fb1_r);
        st_nxt = B_F2;
      end
      B_F2: begin
        m_a = 33'(acc_sh);
        m_b = 33'(fc_r);
        st_nxt = B_F3;
      end
      B_F3: begin
        m_a = 33'(ret_r >>> FRAC_SHIFT);
        m_b = 33'(it_r.gain);
        st_nxt = B_G;
      end
      B_G: st_nxt = B_OUT;
      B_OUT: if (!out_stall) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      rp_r <= '0;
      fc_r <= '0;
      fb0_r <= '0;
      fb1_r <= '0;
      for (int i = 0; i < 3; i++) begin
        ih_r[i] <= '0;
        oh_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      case (st_r)
        B_C0: if (!div_busy) fc_r <= m_hi << (32 - NORM_SHIFT);
        B_C1: fb0_r <= m_hi << (FB_SHIFT - NORM_SHIFT);
        B_C2: fb1_r <= m_hi << (FB_SHIFT - NORM_SHIFT);
        B_F2: begin
          ret_r <= (ret_r << (32 - FB_SHIFT)) + m_hi;
          oh_r[rp_n] <= (ret_r << (32 - FB_SHIFT)) + m_hi;
          ih_r[rp_n] <= it_r.smp;
          rp_r <= rp_n;
        end
        default: ;
      endcase
    end
    case (st_r)
      B_IDLE: if (q_valid) it_r <= q_item;
      B_A1M: if (!div_busy) begin
        a1_r <= m_p[31:0];
        qrec_r <= div_q[31:0];
        a2_r <= 32'(fq * fq);
      end
      B_A1S: a1_r <= 32'(m_hi * 32'sd250);
      B_SUM: sum_r <= a0c + a1_r + a2_r;
      B_C0: if (!div_busy)
        rec_r <= (sum_r > 0) ? div_q[31:0] : 32'sd0;
      B_F0: begin
        acc_r <= 32'(it_r.smp) + 32'sd2 * 32'(ih_r[p0]) + 32'(ih_r[p1]);
        ret_r <= -m_hi;
      end
      B_F1: ret_r <= ret_r - m_hi;
      B_F3: y_r <= m_p;
      default: ;
    endcase
  end

  assign out_valid = (st_r == B_OUT);
  assign out_sample_out = sat;
endmodule
`default_nettype wire

FILE: hdl/biquad_lowpass_fixed_point_core.sv
// ----------------------------------------------------------------------------
// biquad_lowpass_fixed_point_core
// Two-pole fixed-point low-pass with gain and 16-bit saturation.
// ----------------------------------------------------------------------------
// Flow: an item without a coefficient change runs the filter states only; a
// change first runs two passes through the serial divider.
// The back end handles one word at a time; a two-entry queue takes input
// meanwhile.
// Reset: synchronous active-low, clears histories, coefficients and queue.
`default_nettype none
module biquad_lowpass_fixed_point_core
  import bqlp_pkg::*;
#(
  parameter int unsigned GAIN_SHIFT = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_sample_in,
  input  wire logic signed [15:0] in_cutoff,
  input  wire logic signed [15:0] in_resonance,
  input  wire logic signed [15:0] in_gain,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_sample_out
);
  logic q_valid, q_pop;
  bqlp_item_t q_item;

  bqlp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample_in, .in_cutoff,
    .in_resonance, .in_gain, .q_valid, .q_pop, .q_item
  );

  bqlp_back #(.GAIN_SHIFT(GAIN_SHIFT)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_stall,
    .out_sample_out
  );
endmodule
`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the biquad low-pass core against a fixed-point predictor: directed
// corner words, random words, long output hold-off and back-to-back traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import bqlp_pkg::*;

  localparam int GSHIFT   = 12;
  localparam int K_BILIN  = 15287;
  localparam int WDOG_MAX = 5000;
  localparam int HOLD_LEN = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample_in = '0;
  logic signed [15:0] in_cutoff = '0;
  logic signed [15:0] in_resonance = '0;
  logic signed [15:0] in_gain = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_sample_out;

  biquad_lowpass_fixed_point_core #(.GAIN_SHIFT(GSHIFT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_in(in_sample_in), .in_cutoff(in_cutoff),
    .in_resonance(in_resonance), .in_gain(in_gain),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out)
  );

  always #4 clk = ~clk;

  // filter state mirror
  int ring_pos;
  int x_hist[3];
  int y_hist[3];
  int feed_coef;
  int fb_coef[2];
  int prev_cut;
  int prev_res;

  logic signed [15:0] expected_samples[$];
  int  errors = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;

  function automatic void update_coefs(int f, int q);
    int w, a0, a1, a2, sum, rec, t;
    longint qrec;
    if (f < 15) f = 15;
    if (f > 15000) f = 15000;
    if (q < 140) q = 140;
    w = f;
    qrec = longint'(64'h8000_0000 / longint'(q + 1));
    a0 = int'(longint'(K_BILIN) * K_BILIN);
    a1 = int'(longint'(K_BILIN) * w * 8);
    a1 = int'((longint'(a1) * qrec) >>> 32);
    a1 = int'(longint'(a1) * 250);
    a2 = w * w;
    sum = int'(longint'(a0) + a1 + a2);
    if (sum > 0) rec = int'((64'd1 << 57) / longint'(sum));
    else rec = 0;
    t = int'((longint'(a2) * rec) >>> 32);
    feed_coef = t << 7;
    t = int'(64'sd2 * (longint'(a2) - a0));
    t = int'((longint'(t) * rec) >>> 32);
    fb_coef[0] = t << 5;
    t = int'(longint'(a0) - a1 + a2);
    t = int'((longint'(t) * rec) >>> 32);
    fb_coef[1] = t << 5;
  endfunction

  function automatic void reset_filter();
    ring_pos = 0;
    for (int i = 0; i < 3; i++) begin
      x_hist[i] = 0;
      y_hist[i] = 0;
    end
    feed_coef = 0;
    fb_coef[0] = 0;
    fb_coef[1] = 0;
    prev_cut = 16777216;
    prev_res = 0;
  endfunction

  function automatic void filter_word(logic signed [15:0] s, logic signed [15:0] c,
                                      logic signed [15:0] r, logic signed [15:0] g);
    int acc, ret, p;
    longint y;
    if (int'(c) != prev_cut || int'(r) != prev_res) begin
      update_coefs(c, r);
      prev_cut = c;
      prev_res = r;
    end
    ring_pos++;
    if (ring_pos >= 3) ring_pos = 0;
    x_hist[ring_pos] = s;
    acc = s;
    ret = 0;
    for (int i = 0; i < 2; i++) begin
      p = (ring_pos + 2 - i) % 3;
      acc = acc + (2 - i) * x_hist[p];
      ret = int'(longint'(ret) - ((longint'(y_hist[p]) * fb_coef[i]) >>> 32));
    end
    ret = ret << 2;
    acc = acc << 14;
    acc = int'((longint'(acc) * feed_coef) >>> 32);
    ret = ret + acc;
    y_hist[ring_pos] = ret;
    y = longint'(ret) >>> 14;
    y = (y * longint'(g)) >>> GSHIFT;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    expected_samples.push_back(16'(y));
  endfunction

  task automatic send_word(logic signed [15:0] s, logic signed [15:0] c,
                           logic signed [15:0] r, logic signed [15:0] g);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    in_cutoff <= c;
    in_resonance <= r;
    in_gain <= g;
    do @(posedge clk); while (in_stall);
    filter_word(s, c, r, g);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // output check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d", $time, out_sample_out);
        errors++;
      end else begin
        if (out_sample_out !== expected_samples[0]) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, expected_samples[0], out_sample_out);
          errors++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  // receiver stall
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on acceptance activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    logic signed [15:0] cuts[8] = '{-16'sd32768, 16'sd14, 16'sd15, 16'sd16,
                                    16'sd14999, 16'sd15000, 16'sd15001, 16'sd32767};
    logic signed [15:0] ress[5] = '{-16'sd32768, 16'sd139, 16'sd140, 16'sd141, 16'sd32767};
    for (int i = 0; i < 8; i++)
      send_word(i[0] ? 16'sd32767 : -16'sd32768, cuts[i], 16'sd700, 16'sd4096);
    for (int i = 0; i < 5; i++)
      send_word(16'sd12000, 16'sd1000, ress[i], i[0] ? 16'sd32767 : -16'sd32768);
    // same settings repeated: no recompute after the first, ring wraps
    for (int i = 0; i < 6; i++)
      send_word(i[0] ? -16'sd32768 : 16'sd32767, 16'sd15000, 16'sd32767, 16'sd32767);
    send_word(16'sd0, 16'sd15000, 16'sd32767, 16'sd0);
    send_word(-16'sd1, 16'sd15000, 16'sd140, 16'sd4096);
    send_word(16'sd1, 16'sd15000, 16'sd140, -16'sd1);
    // cutoff same, resonance changes raw but clamps to the same value
    send_word(16'sd5000, 16'sd15000, 16'sd100, 16'sd4096);
    send_word(16'sd5000, 16'sd15000, 16'sd139, 16'sd4096);
  endtask

  task automatic test_random(int n);
    logic signed [15:0] c, r, g;
    c = 16'sd1000; r = 16'sd700; g = 16'sd4096;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin c = rnd16(); r = rnd16(); g = rnd16(); end
        1, 2: begin
          c = 16'($urandom_range(15, 15000));
          r = 16'($urandom_range(140, 4000));
          g = 16'($urandom_range(0, 8192));
        end
        default: ;
      endcase
      send_word($urandom_range(0, 3) == 0 ? rnd16() : 16'($signed($urandom_range(0, 16383)) - 8192),
                c, r, g);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++)
      send_word(rnd16(), 16'sd2000, 16'sd707, 16'sd4096);
    wait_drain();
    for (int i = 0; i < 10; i++)
      send_word(rnd16(), 16'($urandom_range(15, 15000)), 16'sd900, 16'sd4096);
  endtask

  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(200);
  endtask

  initial begin
    reset_filter();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1500);
    test_backpressure();
    test_streaming();
    wait_drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
